// ----- hdl/mtep_pkg.sv -----
`default_nettype none
package mtep_pkg;

    typedef struct packed {
        logic       track_start;
        logic [7:0] data_byte;
    } mtep_in_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [31:0] tick;
        logic [3:0]  channel;
        logic [6:0]  key_number;
        logic [6:0]  level;
        logic [13:0] bend;
        logic [8:0]  tempo_bpm;
        logic [7:0]  sig_numerator;
        logic [7:0]  sig_denominator_exp;
        logic [7:0]  clocks_per_click;
    } mtep_out_t;

    localparam logic [2:0] KIND_NOTE_START = 3'd0;
    localparam logic [2:0] KIND_NOTE_END   = 3'd1;
    localparam logic [2:0] KIND_CONTROLLER = 3'd2;
    localparam logic [2:0] KIND_PROGRAM    = 3'd3;
    localparam logic [2:0] KIND_BEND       = 3'd4;
    localparam logic [2:0] KIND_TEMPO      = 3'd5;
    localparam logic [2:0] KIND_TIME_SIG   = 3'd6;

    localparam logic [7:0]  META_TEMPO      = 8'h51;
    localparam logic [7:0]  META_TIME_SIG   = 8'h58;
    localparam logic [7:0]  META_END_TRACK  = 8'h2F;
    localparam logic [7:0]  STATUS_META     = 8'hFF;
    localparam logic [3:0]  CMD_NOTE_OFF    = 4'h8;
    localparam logic [3:0]  CMD_NOTE_ON     = 4'h9;
    localparam logic [3:0]  CMD_POLY        = 4'hA;
    localparam logic [3:0]  CMD_CONTROL     = 4'hB;
    localparam logic [3:0]  CMD_PROGRAM     = 4'hC;
    localparam logic [3:0]  CMD_CHAN_PRESS  = 4'hD;
    localparam logic [13:0] BEND_CENTER     = 14'h2000;
    localparam logic [25:0] TEMPO_DIVIDEND  = 26'd60000000;
    localparam logic [8:0]  BPM_MIN         = 9'd40;
    localparam logic [8:0]  BPM_MAX         = 9'd300;
    localparam logic [8:0]  BPM_DEFAULT     = 9'd100;

    // A decoded event passed from the front end to the back end.
    typedef struct packed {
        mtep_out_t  ev;
        logic       need_div;
        logic [23:0] divisor;
    } mtep_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/mtep_front.sv -----
`default_nettype none
module mtep_front
    import mtep_pkg::*;
#(
    parameter int TICK_BITS = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mtep_in_t  in_word,
    input  wire logic      in_fire,
    output mtep_cmd_t      cmd,
    output logic           cmd_valid
);

    typedef enum logic [2:0] {
        PH_DELTA, PH_STATUS, PH_DATA2, PH_META_TYPE, PH_LEN, PH_BODY, PH_END
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [7:0]           status_reg, status_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic [31:0]          delta_reg, delta_next;
    logic [6:0]           first_reg, first_next;
    logic [7:0]           meta_reg, meta_next;
    logic [31:0]          skip_reg, skip_next;
    logic [23:0]          tempo_reg, tempo_next;
    logic [23:0]          sig_reg, sig_next;

    always_comb
    begin
        phase_t     ph;
        logic [7:0] st;
        logic [TICK_BITS-1:0] tk;
        logic [31:0] dl;
        logic [31:0] sk;
        logic [23:0] tp;
        logic [23:0] sg;
        logic [7:0] b;
        logic [6:0] d;
        logic [6:0] fd;
        logic [13:0] bv;
        logic       chan;
        logic       fin;
        ph = phase_reg; st = status_reg; tk = tick_reg; dl = delta_reg;
        fd = first_reg; sk = skip_reg; tp = tempo_reg; sg = sig_reg;
        meta_next = meta_reg;
        b = in_word.data_byte;
        d = b[6:0];
        bv = '0;
        chan = 1'b0;
        fin = 1'b0;
        cmd = '0;
        cmd_valid = 1'b0;
        if (in_word.track_start)
        begin
            ph = PH_DELTA; st = '0; tk = '0; dl = '0; fd = '0;
            meta_next = '0; sk = '0; tp = '0; sg = '0;
        end
        unique case (ph)
            PH_DELTA, PH_STATUS:
            begin
                if (ph == PH_STATUS && b[7])
                begin
                    if (b < 8'hF0)
                    begin
                        st = b;
                    end
                    else
                    begin
                        st = '0; sk = '0; tp = '0; sg = '0;
                        if (b == STATUS_META)
                        begin
                            ph = PH_META_TYPE;
                        end
                        else
                        begin
                            meta_next = '0;
                            ph = PH_LEN;
                        end
                    end
                end
                else if (ph == PH_DELTA || st == 8'd0)
                begin
                    dl = {dl[24:0], d};
                    if (!b[7])
                    begin
                        tk = tk + TICK_BITS'(dl);
                        dl = '0;
                        ph = PH_STATUS;
                    end
                end
                else
                begin
                    chan = 1'b1;
                end
            end
            PH_DATA2:
            begin
                chan = 1'b1;
            end
            PH_META_TYPE:
            begin
                meta_next = b;
                ph = (b == META_END_TRACK) ? PH_END : PH_LEN;
            end
            PH_LEN:
            begin
                sk = {sk[24:0], d};
                if (!b[7])
                begin
                    fd = '0;
                    if (sk == 32'd0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        ph = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (fd < 7'd3)
                begin
                    if (meta_next == META_TEMPO)
                    begin
                        tp = {tp[15:0], b};
                    end
                    else if (meta_next == META_TIME_SIG)
                    begin
                        unique case (fd[1:0])
                            2'd0:    sg[23:16] = sg[23:16] | b;
                            2'd1:    sg[15:8]  = sg[15:8] | b;
                            default: sg[7:0]   = sg[7:0] | b;
                        endcase
                    end
                    fd = fd + 7'd1;
                end
                sk = sk - 32'd1;
                if (sk == 32'd0)
                begin
                    fin = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        cmd.ev.tick = 32'(tk);
        if (chan)
        begin
            cmd.ev.channel = st[3:0];
            if (ph == PH_STATUS)
            begin
                if (st[7:4] == CMD_PROGRAM)
                begin
                    ph = PH_DELTA;
                    cmd_valid = 1'b1;
                    cmd.ev.event_kind = KIND_PROGRAM;
                    cmd.ev.key_number = d;
                end
                else if (st[7:4] == CMD_CHAN_PRESS)
                begin
                    ph = PH_DELTA;
                end
                else
                begin
                    fd = d;
                    ph = PH_DATA2;
                end
            end
            else
            begin
                ph = PH_DELTA;
                cmd_valid = 1'b1;
                cmd.ev.key_number = fd;
                if (st[7:4] == CMD_NOTE_OFF ||
                    ((st[7:4] == CMD_NOTE_ON || st[7:4] == CMD_POLY) && d == 7'd0))
                begin
                    cmd.ev.event_kind = KIND_NOTE_END;
                end
                else if (st[7:4] == CMD_NOTE_ON || st[7:4] == CMD_POLY)
                begin
                    cmd.ev.event_kind = KIND_NOTE_START;
                    cmd.ev.level = d;
                end
                else if (st[7:4] == CMD_CONTROL)
                begin
                    cmd.ev.event_kind = KIND_CONTROLLER;
                    cmd.ev.level = d;
                end
                else
                begin
                    cmd.ev.event_kind = KIND_BEND;
                    cmd.ev.key_number = '0;
                    bv = {d, fd};
                    cmd.ev.bend = bv - BEND_CENTER;
                end
            end
        end
        if (fin)
        begin
            ph = PH_DELTA;
            if (meta_next == META_TEMPO)
            begin
                cmd_valid = 1'b1;
                cmd.ev.event_kind = KIND_TEMPO;
                cmd.need_div = (tp != 24'd0);
                cmd.divisor = tp;
                cmd.ev.tempo_bpm = BPM_DEFAULT;
            end
            else if (meta_next == META_TIME_SIG)
            begin
                cmd_valid = 1'b1;
                cmd.ev.event_kind = KIND_TIME_SIG;
                cmd.ev.sig_numerator = sg[23:16];
                cmd.ev.sig_denominator_exp = sg[15:8];
                cmd.ev.clocks_per_click = sg[7:0];
            end
        end
        phase_next = ph; status_next = st; tick_next = tk; delta_next = dl;
        first_next = fd; skip_next = sk; tempo_next = tp; sig_next = sg;
        cmd_valid = cmd_valid & in_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DELTA;
            status_reg <= '0;
            tick_reg   <= '0;
            delta_reg  <= '0;
            first_reg  <= '0;
            meta_reg   <= '0;
            skip_reg   <= '0;
            tempo_reg  <= '0;
            sig_reg    <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            tick_reg   <= tick_next;
            delta_reg  <= delta_next;
            first_reg  <= first_next;
            meta_reg   <= meta_next;
            skip_reg   <= skip_next;
            tempo_reg  <= tempo_next;
            sig_reg    <= sig_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/mtep_queue.sv -----
`default_nettype none
module mtep_queue
    import mtep_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mtep_cmd_t wr_data,
    input  wire logic      wr_en,
    output logic           almost_full,
    output mtep_cmd_t      rd_data,
    output logic           rd_valid,
    input  wire logic      rd_en
);

    localparam int DEPTH = 4;

    mtep_cmd_t  mem_reg [DEPTH];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] count_reg;

    assign rd_data     = mem_reg[rptr_reg];
    assign rd_valid    = (count_reg != 3'd0);
    assign almost_full = (count_reg >= 3'(DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(wr_en) - 3'(rd_en);
        end
    end

endmodule
`default_nettype wire

// ----- hdl/mtep_back.sv -----
`default_nettype none
module mtep_back
    import mtep_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mtep_cmd_t cmd,
    input  wire logic      cmd_valid,
    output logic           cmd_take,
    output mtep_out_t      out_word,
    output logic           out_valid,
    input  wire logic      out_ready
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SHOW} state_t;

    state_t      state_reg;
    mtep_out_t   word_reg;
    logic [25:0] rem_reg;
    logic [25:0] quo_reg;
    logic [23:0] div_reg;
    logic [4:0]  cnt_reg;

    logic [26:0] trial;
    logic [25:0] quo_fin;

    assign trial    = {rem_reg, quo_reg[25]} - {3'd0, div_reg};
    assign quo_fin  = {quo_reg[24:0], !trial[26]};
    assign out_word = word_reg;
    assign out_valid = (state_reg == S_SHOW);
    assign cmd_take = cmd_valid && (state_reg == S_IDLE ||
                      (state_reg == S_SHOW && out_ready)) && !cmd.need_div
                      || cmd_valid && state_reg == S_IDLE;

    // Restoring division, one quotient bit a cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            word_reg  <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            div_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE, S_SHOW:
                begin
                    if (state_reg == S_SHOW && out_ready && !cmd_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                    if (cmd_take)
                    begin
                        word_reg <= cmd.ev;
                        if (cmd.need_div)
                        begin
                            state_reg <= S_DIV;
                            rem_reg   <= '0;
                            quo_reg   <= TEMPO_DIVIDEND;
                            div_reg   <= cmd.divisor;
                            cnt_reg   <= 5'd25;
                        end
                        else
                        begin
                            state_reg <= S_SHOW;
                        end
                    end
                end
                S_DIV:
                begin
                    if (!trial[26])
                    begin
                        rem_reg <= trial[25:0];
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[24:0], quo_reg[25]};
                    end
                    quo_reg <= quo_fin;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= S_SHOW;
                        if (quo_fin >= 26'(BPM_MIN) && quo_fin <= 26'(BPM_MAX))
                        begin
                            word_reg.tempo_bpm <= quo_fin[8:0];
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hdl/midi_track_event_parser.sv -----
// Channel  Direction  Handshake      Payload
// in       input      valid / ready  mtep_in_t  (track_start, data_byte)
// out      output     valid / ready  mtep_out_t (event fields)
// One byte is taken per cycle while the event queue has room.
// An event is written into the queue with its last byte, then registered in the back end before it leaves.
// A tempo event with a nonzero tempo value holds the back end in its bit-serial divider.
// Reset clears parse state, tick, queue and output register.
// When the queue nears full, in_ready drops until the back end drains it.
`default_nettype none
module midi_track_event_parser
    import mtep_pkg::*;
#(
    parameter int TICK_BITS = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire mtep_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output mtep_out_t      out_data
);

    mtep_cmd_t f_cmd, q_cmd;
    logic      f_valid, q_valid, q_take, q_full, in_fire;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    mtep_front #(.TICK_BITS(TICK_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_word(in_data), .in_fire(in_fire),
        .cmd(f_cmd), .cmd_valid(f_valid)
    );

    mtep_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(f_cmd), .wr_en(f_valid),
        .almost_full(q_full), .rd_data(q_cmd), .rd_valid(q_valid), .rd_en(q_take)
    );

    mtep_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd(q_cmd), .cmd_valid(q_valid), .cmd_take(q_take),
        .out_word(out_data), .out_valid(out_valid), .out_ready(out_ready)
    );

endmodule
`default_nettype wire

// ----- hdl/mtep_checker.sv -----
`default_nettype none
module mtep_checker
    import mtep_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire mtep_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.event_kind <= KIND_TIME_SIG)
        else $error("bad event kind");

    a_bpm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_kind == KIND_TEMPO |->
        out_data.tempo_bpm >= BPM_MIN && out_data.tempo_bpm <= BPM_MAX)
        else $error("tempo out of range");

    a_chan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_kind > KIND_BEND |-> out_data.channel == 4'd0)
        else $error("meta event with channel");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
